// ===== src/p2h_pkg.sv =====
`default_nettype none

package p2h_pkg;

   // pipeline depth, input register to output register
   localparam int NUM_STAGES = 10;

   localparam int PIX_W = 16;
   localparam int DIFF_W = PIX_W + 1;
   localparam int INV_W = 20;
   localparam int COEF_W = 16;
   localparam int SIZE_FRAC_BITS = 16;
   // scaled coordinate: |dx| * inv fits 36 bits plus sign
   localparam int FX_W = 37;
   // fx is split into an unsigned low part and a signed high part
   localparam int FX_LO_W = 21;
   localparam int FX_HI_W = FX_W - FX_LO_W;
   localparam int PLO_W = 37;
   localparam int PHI_W = COEF_W + FX_HI_W;
   localparam int SLO_W = PLO_W + 1;
   localparam int SHI_W = PHI_W + 1;
   // fractional q, r, s with all fraction bits kept
   localparam int VAL_W = SHI_W + FX_LO_W;
   localparam int CELL_W = 19;
   localparam int CELL_MAX = 262143;
   localparam int CELL_MIN = -262144;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_INV_CELL_WIDTH = 3'd2,
      CSR_INV_CELL_HEIGHT = 3'd3,
      CSR_COEF_QX = 3'd4,
      CSR_COEF_QY = 3'd5,
      CSR_COEF_RX = 3'd6,
      CSR_COEF_RY = 3'd7
   } csr_index_type;

   localparam int CSR_DATA_W = INV_W;

   localparam logic signed [PIX_W-1:0] RST_ORIGIN_X = 16'sd0;
   localparam logic signed [PIX_W-1:0] RST_ORIGIN_Y = 16'sd0;
   localparam logic [INV_W-1:0] RST_INV_CELL_WIDTH = 20'd65536;
   localparam logic [INV_W-1:0] RST_INV_CELL_HEIGHT = 20'd65536;
   localparam logic signed [COEF_W-1:0] RST_COEF_QX = 16'sd9459;
   localparam logic signed [COEF_W-1:0] RST_COEF_QY = -16'sd5461;
   localparam logic signed [COEF_W-1:0] RST_COEF_RX = 16'sd0;
   localparam logic signed [COEF_W-1:0] RST_COEF_RY = 16'sd10923;

   typedef struct packed {
      logic signed [PIX_W-1:0] origin_x;
      logic signed [PIX_W-1:0] origin_y;
      logic [INV_W-1:0] inv_cell_width;
      logic [INV_W-1:0] inv_cell_height;
      logic signed [COEF_W-1:0] coef_qx;
      logic signed [COEF_W-1:0] coef_qy;
      logic signed [COEF_W-1:0] coef_rx;
      logic signed [COEF_W-1:0] coef_ry;
   } cfg_type;

   // which cube component gets rebuilt from the other two
   typedef enum logic [1:0] {
      FIX_Q = 2'd0,
      FIX_R = 2'd1,
      FIX_S = 2'd2
   } fix_sel_type;

endpackage

`default_nettype wire

// ===== src/p2h_pipe_ctrl.sv =====
`default_nettype none

module p2h_pipe_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire logic out_ready,
   output logic out_valid,
   output logic [p2h_pkg::NUM_STAGES-1:0] load
);

   logic [p2h_pkg::NUM_STAGES-1:0] valid_ff;
   logic [p2h_pkg::NUM_STAGES-1:0] valid_in;
   logic [p2h_pkg::NUM_STAGES:0] rdy;

   // a stage takes new data when it is empty or its successor takes its data
   always_comb begin
      rdy[p2h_pkg::NUM_STAGES] = out_ready;
      for (int i = p2h_pkg::NUM_STAGES - 1; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
   end

   always_comb begin
      for (int i = 0; i < p2h_pkg::NUM_STAGES; i++) begin
         load[i] = rdy[i];
         if (rdy[i]) begin
            valid_in[i] = (i == 0) ? in_valid : valid_ff[(i == 0) ? 0 : i - 1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready = rdy[0];
   assign out_valid = valid_ff[p2h_pkg::NUM_STAGES-1];

endmodule

`default_nettype wire

// ===== src/p2h_scale.sv =====
`default_nettype none

module p2h_scale (
   input wire logic clock,
   input wire logic [1:0] load,
   input wire p2h_pkg::cfg_type cfg,
   input wire logic signed [p2h_pkg::PIX_W-1:0] pixel_x,
   input wire logic signed [p2h_pkg::PIX_W-1:0] pixel_y,
   output logic signed [p2h_pkg::FX_W-1:0] fx,
   output logic signed [p2h_pkg::FX_W-1:0] fy
);

   localparam int PROD_W = p2h_pkg::DIFF_W + p2h_pkg::INV_W + 1;

   logic signed [p2h_pkg::DIFF_W-1:0] dx_ff, dx_in;
   logic signed [p2h_pkg::DIFF_W-1:0] dy_ff, dy_in;
   logic signed [p2h_pkg::FX_W-1:0] fx_ff, fx_in;
   logic signed [p2h_pkg::FX_W-1:0] fy_ff, fy_in;
   logic signed [PROD_W-1:0] prod_x;
   logic signed [PROD_W-1:0] prod_y;

   // stage 1: offset from the layout origin
   assign dx_in = $signed({pixel_x[p2h_pkg::PIX_W-1], pixel_x})
                - $signed({cfg.origin_x[p2h_pkg::PIX_W-1], cfg.origin_x});
   assign dy_in = $signed({pixel_y[p2h_pkg::PIX_W-1], pixel_y})
                - $signed({cfg.origin_y[p2h_pkg::PIX_W-1], cfg.origin_y});

   // stage 2: scale by the reciprocal cell size
   assign prod_x = dx_ff * $signed({1'b0, cfg.inv_cell_width});
   assign prod_y = dy_ff * $signed({1'b0, cfg.inv_cell_height});
   assign fx_in = prod_x[p2h_pkg::FX_W-1:0];
   assign fy_in = prod_y[p2h_pkg::FX_W-1:0];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (load[1]) begin
         fx_ff <= fx_in;
         fy_ff <= fy_in;
      end
   end

   assign fx = fx_ff;
   assign fy = fy_ff;

endmodule

`default_nettype wire

// ===== src/p2h_matrix.sv =====
`default_nettype none

module p2h_matrix (
   input wire logic clock,
   input wire logic [2:0] load,
   input wire p2h_pkg::cfg_type cfg,
   input wire logic signed [p2h_pkg::FX_W-1:0] fx,
   input wire logic signed [p2h_pkg::FX_W-1:0] fy,
   output logic signed [p2h_pkg::VAL_W-1:0] fq,
   output logic signed [p2h_pkg::VAL_W-1:0] fr
);

   localparam int LO_PROD_W = p2h_pkg::COEF_W + p2h_pkg::FX_LO_W + 1;

   // lanes: 0 qx, 1 qy, 2 rx, 3 ry
   logic signed [p2h_pkg::COEF_W-1:0] coef [0:3];
   logic signed [p2h_pkg::FX_W-1:0] src [0:3];
   logic signed [LO_PROD_W-1:0] lo_prod [0:3];

   logic signed [p2h_pkg::PLO_W-1:0] plo_ff [0:3];
   logic signed [p2h_pkg::PLO_W-1:0] plo_in [0:3];
   logic signed [p2h_pkg::PHI_W-1:0] phi_ff [0:3];
   logic signed [p2h_pkg::PHI_W-1:0] phi_in [0:3];

   logic signed [p2h_pkg::SLO_W-1:0] slo_q_ff, slo_q_in, slo_r_ff, slo_r_in;
   logic signed [p2h_pkg::SHI_W-1:0] shi_q_ff, shi_q_in, shi_r_ff, shi_r_in;

   logic signed [p2h_pkg::VAL_W-1:0] fq_ff, fq_in, fr_ff, fr_in;

   assign coef[0] = cfg.coef_qx;
   assign coef[1] = cfg.coef_qy;
   assign coef[2] = cfg.coef_rx;
   assign coef[3] = cfg.coef_ry;
   assign src[0] = fx;
   assign src[1] = fy;
   assign src[2] = fx;
   assign src[3] = fy;

   // stage 3: each coefficient times the low and high halves of its coordinate
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lo_prod[i] = coef[i] * $signed({1'b0, src[i][p2h_pkg::FX_LO_W-1:0]});
         plo_in[i] = lo_prod[i][p2h_pkg::PLO_W-1:0];
         phi_in[i] = coef[i] * $signed(src[i][p2h_pkg::FX_W-1:p2h_pkg::FX_LO_W]);
      end
   end

   // stage 4: add the halves of the two terms separately
   assign slo_q_in = $signed({plo_ff[0][p2h_pkg::PLO_W-1], plo_ff[0]})
                   + $signed({plo_ff[1][p2h_pkg::PLO_W-1], plo_ff[1]});
   assign slo_r_in = $signed({plo_ff[2][p2h_pkg::PLO_W-1], plo_ff[2]})
                   + $signed({plo_ff[3][p2h_pkg::PLO_W-1], plo_ff[3]});
   assign shi_q_in = $signed({phi_ff[0][p2h_pkg::PHI_W-1], phi_ff[0]})
                   + $signed({phi_ff[1][p2h_pkg::PHI_W-1], phi_ff[1]});
   assign shi_r_in = $signed({phi_ff[2][p2h_pkg::PHI_W-1], phi_ff[2]})
                   + $signed({phi_ff[3][p2h_pkg::PHI_W-1], phi_ff[3]});

   // stage 5: recombine the halves
   assign fq_in = $signed({shi_q_ff, {p2h_pkg::FX_LO_W{1'b0}}})
                + $signed({{(p2h_pkg::VAL_W - p2h_pkg::SLO_W){slo_q_ff[p2h_pkg::SLO_W-1]}},
                           slo_q_ff});
   assign fr_in = $signed({shi_r_ff, {p2h_pkg::FX_LO_W{1'b0}}})
                + $signed({{(p2h_pkg::VAL_W - p2h_pkg::SLO_W){slo_r_ff[p2h_pkg::SLO_W-1]}},
                           slo_r_ff});

   always_ff @(posedge clock) begin
      if (load[0]) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      if (load[1]) begin
         slo_q_ff <= slo_q_in;
         slo_r_ff <= slo_r_in;
         shi_q_ff <= shi_q_in;
         shi_r_ff <= shi_r_in;
      end
      if (load[2]) begin
         fq_ff <= fq_in;
         fr_ff <= fr_in;
      end
   end

   assign fq = fq_ff;
   assign fr = fr_ff;

endmodule

`default_nettype wire

// ===== src/p2h_round.sv =====
`default_nettype none

module p2h_round #(
   parameter int COEF_FRAC_BITS = 14
) (
   input wire logic clock,
   input wire logic [4:0] load,
   input wire logic signed [p2h_pkg::VAL_W-1:0] fq,
   input wire logic signed [p2h_pkg::VAL_W-1:0] fr,
   output logic signed [p2h_pkg::CELL_W-1:0] cell_q,
   output logic signed [p2h_pkg::CELL_W-1:0] cell_r,
   output logic signed [p2h_pkg::CELL_W-1:0] cell_s
);

   localparam int TOTAL_FRAC = p2h_pkg::SIZE_FRAC_BITS + COEF_FRAC_BITS;
   localparam int MAG_W = p2h_pkg::VAL_W - TOTAL_FRAC + 1;
   localparam int N_W = MAG_W + 1;
   localparam int SUM_W = N_W + 1;
   localparam logic signed [SUM_W-1:0] LIM_MAX = SUM_W'(p2h_pkg::CELL_MAX);
   localparam logic signed [SUM_W-1:0] LIM_MIN = SUM_W'(p2h_pkg::CELL_MIN);

   // lanes: 0 q, 1 r, 2 s
   logic signed [p2h_pkg::VAL_W-1:0] v_ff [0:2];
   logic signed [p2h_pkg::VAL_W-1:0] v_in [0:2];
   logic [p2h_pkg::VAL_W-1:0] abs_ff [0:2];
   logic [p2h_pkg::VAL_W-1:0] abs_in [0:2];
   logic [2:0] neg7_ff, neg7_in, neg8_ff;
   logic [MAG_W-1:0] mag_ff [0:2];
   logic [MAG_W-1:0] mag_in [0:2];
   logic [TOTAL_FRAC-1:0] err_ff [0:2];
   logic [TOTAL_FRAC-1:0] err_in [0:2];
   logic [TOTAL_FRAC-1:0] frac [0:2];
   logic signed [N_W-1:0] n_ff [0:2];
   logic signed [N_W-1:0] n_in [0:2];
   p2h_pkg::fix_sel_type sel_ff, sel_in;
   logic signed [SUM_W-1:0] res [0:2];
   logic signed [p2h_pkg::CELL_W-1:0] cell_ff [0:2];
   logic signed [p2h_pkg::CELL_W-1:0] cell_in [0:2];

   // stage 6: s from q and r
   assign v_in[0] = fq;
   assign v_in[1] = fr;
   assign v_in[2] = -fq - fr;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // stage 7: magnitude and sign
         neg7_in[i] = v_ff[i][p2h_pkg::VAL_W-1];
         abs_in[i] = neg7_in[i] ? p2h_pkg::VAL_W'(-v_ff[i]) : p2h_pkg::VAL_W'(v_ff[i]);
         // stage 8: round the magnitude half up, error is distance to nearest integer
         frac[i] = abs_ff[i][TOTAL_FRAC-1:0];
         mag_in[i] = MAG_W'(abs_ff[i][p2h_pkg::VAL_W-1:TOTAL_FRAC])
                   + MAG_W'(abs_ff[i][TOTAL_FRAC-1]);
         err_in[i] = frac[i][TOTAL_FRAC-1] ? (~frac[i] + 1'b1) : frac[i];
         // stage 9: restore the sign
         n_in[i] = neg8_ff[i] ? -$signed({1'b0, mag_ff[i]}) : $signed({1'b0, mag_ff[i]});
      end
   end

   // stage 9: pick the component with the largest error; ties go to r, then s
   always_comb begin
      if (err_ff[0] > err_ff[1] && err_ff[0] > err_ff[2]) begin
         sel_in = p2h_pkg::FIX_Q;
      end else if (err_ff[1] > err_ff[2]) begin
         sel_in = p2h_pkg::FIX_R;
      end else begin
         sel_in = p2h_pkg::FIX_S;
      end
   end

   // stage 10: rebuild the chosen component, then saturate each one
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         res[i] = SUM_W'(n_ff[i]);
      end
      case (sel_ff)
         p2h_pkg::FIX_Q: res[0] = -SUM_W'(n_ff[1]) - SUM_W'(n_ff[2]);
         p2h_pkg::FIX_R: res[1] = -SUM_W'(n_ff[0]) - SUM_W'(n_ff[2]);
         p2h_pkg::FIX_S: res[2] = -SUM_W'(n_ff[0]) - SUM_W'(n_ff[1]);
         default: res[2] = -SUM_W'(n_ff[0]) - SUM_W'(n_ff[1]);
      endcase
      for (int i = 0; i < 3; i++) begin
         if (res[i] > LIM_MAX) begin
            cell_in[i] = p2h_pkg::CELL_W'(p2h_pkg::CELL_MAX);
         end else if (res[i] < LIM_MIN) begin
            cell_in[i] = p2h_pkg::CELL_W'(p2h_pkg::CELL_MIN);
         end else begin
            cell_in[i] = res[i][p2h_pkg::CELL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         v_ff <= v_in;
      end
      if (load[1]) begin
         abs_ff <= abs_in;
         neg7_ff <= neg7_in;
      end
      if (load[2]) begin
         mag_ff <= mag_in;
         err_ff <= err_in;
         neg8_ff <= neg7_ff;
      end
      if (load[3]) begin
         n_ff <= n_in;
         sel_ff <= sel_in;
      end
      if (load[4]) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_q = cell_ff[0];
   assign cell_r = cell_ff[1];
   assign cell_s = cell_ff[2];

endmodule

`default_nettype wire

// ===== src/pixel_to_hex_cell.sv =====
`default_nettype none

// channel   direction  contents
// req_      in         tdata: pixel_x [15:0], pixel_y [31:16]
// rsp_      out        tdata: cell_q [18:0], cell_r [37:19], cell_s [56:38], zeros above
// csr_      in         write enable, 3-bit register index, 20-bit data
//
// ten register stages, from the input register to the output register
// one item per cycle unless the output stalls; 16x22 low and 16x16 high halves of each matrix product set the split
// reset clears the valid bits and loads the default layout registers
// each stage has its own valid bit: empty stages keep filling while the output waits
module pixel_to_hex_cell #(
   parameter int COEF_FRAC_BITS = 14
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [31:0] req_tdata, // pixel_x, pixel_y
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [63:0] rsp_tdata, // cell_q, cell_r, cell_s
   input wire logic csr_we,
   input wire logic [2:0] csr_addr,
   input wire logic [p2h_pkg::CSR_DATA_W-1:0] csr_wdata
);

   p2h_pkg::cfg_type cfg_ff, cfg_in;
   logic [p2h_pkg::NUM_STAGES-1:0] load;
   logic signed [p2h_pkg::FX_W-1:0] fx, fy;
   logic signed [p2h_pkg::VAL_W-1:0] fq, fr;
   logic signed [p2h_pkg::CELL_W-1:0] cell_q, cell_r, cell_s;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (p2h_pkg::csr_index_type'(csr_addr))
            p2h_pkg::CSR_ORIGIN_X: cfg_in.origin_x = csr_wdata[p2h_pkg::PIX_W-1:0];
            p2h_pkg::CSR_ORIGIN_Y: cfg_in.origin_y = csr_wdata[p2h_pkg::PIX_W-1:0];
            p2h_pkg::CSR_INV_CELL_WIDTH: cfg_in.inv_cell_width = csr_wdata;
            p2h_pkg::CSR_INV_CELL_HEIGHT: cfg_in.inv_cell_height = csr_wdata;
            p2h_pkg::CSR_COEF_QX: cfg_in.coef_qx = csr_wdata[p2h_pkg::COEF_W-1:0];
            p2h_pkg::CSR_COEF_QY: cfg_in.coef_qy = csr_wdata[p2h_pkg::COEF_W-1:0];
            p2h_pkg::CSR_COEF_RX: cfg_in.coef_rx = csr_wdata[p2h_pkg::COEF_W-1:0];
            p2h_pkg::CSR_COEF_RY: cfg_in.coef_ry = csr_wdata[p2h_pkg::COEF_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x <= p2h_pkg::RST_ORIGIN_X;
         cfg_ff.origin_y <= p2h_pkg::RST_ORIGIN_Y;
         cfg_ff.inv_cell_width <= p2h_pkg::RST_INV_CELL_WIDTH;
         cfg_ff.inv_cell_height <= p2h_pkg::RST_INV_CELL_HEIGHT;
         cfg_ff.coef_qx <= p2h_pkg::RST_COEF_QX;
         cfg_ff.coef_qy <= p2h_pkg::RST_COEF_QY;
         cfg_ff.coef_rx <= p2h_pkg::RST_COEF_RX;
         cfg_ff.coef_ry <= p2h_pkg::RST_COEF_RY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   p2h_pipe_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .out_ready(rsp_tready),
      .out_valid(rsp_tvalid),
      .load(load)
   );

   p2h_scale u_scale (
      .clock(clock),
      .load(load[1:0]),
      .cfg(cfg_ff),
      .pixel_x(req_tdata[15:0]),
      .pixel_y(req_tdata[31:16]),
      .fx(fx),
      .fy(fy)
   );

   p2h_matrix u_matrix (
      .clock(clock),
      .load(load[4:2]),
      .cfg(cfg_ff),
      .fx(fx),
      .fy(fy),
      .fq(fq),
      .fr(fr)
   );

   p2h_round #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_round (
      .clock(clock),
      .load(load[9:5]),
      .fq(fq),
      .fr(fr),
      .cell_q(cell_q),
      .cell_r(cell_r),
      .cell_s(cell_s)
   );

   assign rsp_tdata = {7'b0, cell_s, cell_r, cell_q};

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COEF_FRAC_BITS = 14;
   localparam int FRAC = p2h_pkg::SIZE_FRAC_BITS + COEF_FRAC_BITS;
   localparam int RUN_PIXELS = 1050;

   typedef struct packed {
      logic signed [p2h_pkg::CELL_W-1:0] q;
      logic signed [p2h_pkg::CELL_W-1:0] r;
      logic signed [p2h_pkg::CELL_W-1:0] s;
   } hex_cell_type;

   typedef struct {
      int lay;
      logic signed [p2h_pkg::PIX_W-1:0] px;
      logic signed [p2h_pkg::PIX_W-1:0] py;
      bit typed;
      hex_cell_type want;
   } pixel_row_type;

   typedef enum {LAY_HEX, LAY_HALF, LAY_WILD} lay_kind_type;
   typedef enum {SINK_FREE, SINK_JITTER, SINK_PERIODIC, SINK_SLOW} sink_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic csr_we = 1'b0;
   p2h_pkg::csr_index_type csr_addr = p2h_pkg::CSR_ORIGIN_X;
   logic [p2h_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // layouts used by the directed rows: reset values, half steps, zero reciprocal, saturation
   p2h_pkg::cfg_type dir_lay [4] = '{
      '{p2h_pkg::RST_ORIGIN_X, p2h_pkg::RST_ORIGIN_Y, p2h_pkg::RST_INV_CELL_WIDTH,
        p2h_pkg::RST_INV_CELL_HEIGHT, p2h_pkg::RST_COEF_QX, p2h_pkg::RST_COEF_QY,
        p2h_pkg::RST_COEF_RX, p2h_pkg::RST_COEF_RY},
      '{0, 0, 65536, 65536, 8192, 0, 0, 8192},
      '{100, -200, 0, 0, 9459, -5461, 0, 10923},
      '{0, -32768, 20'hFFFFF, 0, -32768, 0, 0, 0}
   };

   pixel_row_type dir_rows [21] = '{
      '{0, 0, 0, 1'b1, '{0, 0, 0}},
      '{0, 32767, 32767, 1'b0, '{0, 0, 0}},
      '{0, -32768, -32768, 1'b0, '{0, 0, 0}},
      '{0, 32767, -32768, 1'b0, '{0, 0, 0}},
      '{0, -32768, 32767, 1'b0, '{0, 0, 0}},
      '{0, 1, 0, 1'b0, '{0, 0, 0}},
      '{0, 0, 1, 1'b0, '{0, 0, 0}},
      '{0, -1, -1, 1'b0, '{0, 0, 0}},
      '{1, 1, 0, 1'b0, '{0, 0, 0}},
      '{1, -1, 0, 1'b0, '{0, 0, 0}},
      '{1, 1, 1, 1'b0, '{0, 0, 0}},
      '{1, -1, -1, 1'b0, '{0, 0, 0}},
      '{1, 3, 1, 1'b0, '{0, 0, 0}},
      '{1, 0, 1, 1'b0, '{0, 0, 0}},
      '{1, 2, 3, 1'b0, '{0, 0, 0}},
      '{1, -3, 5, 1'b0, '{0, 0, 0}},
      '{2, 12345, -23456, 1'b1, '{0, 0, 0}},
      '{2, -32768, 32767, 1'b1, '{0, 0, 0}},
      '{3, -32768, 32767, 1'b1, '{p2h_pkg::CELL_W'(p2h_pkg::CELL_MAX), 0,
                                  p2h_pkg::CELL_W'(p2h_pkg::CELL_MIN)}},
      '{3, 32767, -32768, 1'b1, '{p2h_pkg::CELL_W'(p2h_pkg::CELL_MIN), 0,
                                  p2h_pkg::CELL_W'(p2h_pkg::CELL_MAX)}},
      '{3, 0, 0, 1'b1, '{0, 0, 0}}
   };

   p2h_pkg::cfg_type lay;
   hex_cell_type pending_cells [$];
   hex_cell_type no_cell = '0;
   int mismatches = 0;
   int pixels_sent = 0;
   int cells_checked = 0;
   int layouts_loaded = 0;
   int burst_left = 0;
   sink_mode_type sink_mode = SINK_FREE;
   int sink_left = 0;
   int sink_tick = 0;

   pixel_to_hex_cell #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   // round to nearest, halfway goes away from zero
   function automatic longint round_away(longint v);
      longint half;
      half = longint'(1) << (FRAC - 1);
      if (v >= 0) return (v + half) >>> FRAC;
      return -((-v + half) >>> FRAC);
   endfunction

   function automatic longint round_gap(longint n, longint v);
      longint d;
      d = n * (longint'(1) << FRAC) - v;
      return (d < 0) ? -d : d;
   endfunction

   function automatic logic signed [p2h_pkg::CELL_W-1:0] clamp_cell(longint v);
      if (v > p2h_pkg::CELL_MAX) return p2h_pkg::CELL_W'(p2h_pkg::CELL_MAX);
      if (v < p2h_pkg::CELL_MIN) return p2h_pkg::CELL_W'(p2h_pkg::CELL_MIN);
      return p2h_pkg::CELL_W'(v);
   endfunction

   function automatic hex_cell_type locate_cell(logic signed [p2h_pkg::PIX_W-1:0] px,
                                                logic signed [p2h_pkg::PIX_W-1:0] py);
      longint fx, fy, fq, fr, fs, q, r, s, eq, er, es;
      hex_cell_type c;
      fx = (longint'(px) - longint'($signed(lay.origin_x))) * longint'(lay.inv_cell_width);
      fy = (longint'(py) - longint'($signed(lay.origin_y))) * longint'(lay.inv_cell_height);
      fq = longint'($signed(lay.coef_qx)) * fx + longint'($signed(lay.coef_qy)) * fy;
      fr = longint'($signed(lay.coef_rx)) * fx + longint'($signed(lay.coef_ry)) * fy;
      fs = -fq - fr;
      q = round_away(fq);
      r = round_away(fr);
      s = round_away(fs);
      eq = round_gap(q, fq);
      er = round_gap(r, fr);
      es = round_gap(s, fs);
      // rebuild the worst rounded component; error ties fall through to r, then s
      if (eq > er && eq > es) q = -r - s;
      else if (er > es) r = -q - s;
      else s = -q - r;
      c.q = clamp_cell(q);
      c.r = clamp_cell(r);
      c.s = clamp_cell(s);
      return c;
   endfunction

   function automatic logic [p2h_pkg::PIX_W-1:0] wild16();
      case ($urandom_range(0, 3))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [p2h_pkg::INV_W-1:0] wild20();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return 20'hFFFFF;
         default: return 20'($urandom);
      endcase
   endfunction

   function automatic logic signed [p2h_pkg::COEF_W-1:0] half_step_coef();
      return 16'(4096 * (int'($urandom_range(0, 8)) - 4));
   endfunction

   function automatic logic [p2h_pkg::INV_W-1:0] half_step_inv();
      if ($urandom_range(0, 7) == 0) return '0;
      return 20'(16384 << $urandom_range(0, 3));
   endfunction

   function automatic p2h_pkg::cfg_type make_layout(lay_kind_type kind);
      p2h_pkg::cfg_type c;
      case (kind)
         LAY_HEX: begin
            c.origin_x = 16'(int'($urandom_range(0, 4000)) - 2000);
            c.origin_y = 16'(int'($urandom_range(0, 4000)) - 2000);
            c.inv_cell_width = 20'(65536 / $urandom_range(1, 64));
            c.inv_cell_height = 20'(65536 / $urandom_range(1, 64));
            if ($urandom_range(0, 1) == 0) begin
               // pointy top
               c.coef_qx = 9459;
               c.coef_qy = -5461;
               c.coef_rx = 0;
               c.coef_ry = 10923;
            end else begin
               // flat top
               c.coef_qx = 10923;
               c.coef_qy = 0;
               c.coef_rx = -5461;
               c.coef_ry = 9459;
            end
         end
         LAY_HALF: begin
            c.origin_x = 16'(int'($urandom_range(0, 200)) - 100);
            c.origin_y = 16'(int'($urandom_range(0, 200)) - 100);
            c.inv_cell_width = half_step_inv();
            c.inv_cell_height = half_step_inv();
            c.coef_qx = half_step_coef();
            c.coef_qy = half_step_coef();
            c.coef_rx = half_step_coef();
            c.coef_ry = half_step_coef();
         end
         default: begin
            c.origin_x = wild16();
            c.origin_y = wild16();
            c.inv_cell_width = wild20();
            c.inv_cell_height = wild20();
            c.coef_qx = wild16();
            c.coef_qy = wild16();
            c.coef_rx = wild16();
            c.coef_ry = wild16();
         end
      endcase
      return c;
   endfunction

   function automatic logic signed [p2h_pkg::PIX_W-1:0] pick_coord(
         lay_kind_type kind, logic signed [p2h_pkg::PIX_W-1:0] org);
      if (kind == LAY_WILD) begin
         if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h7FFF;
         return 16'($urandom);
      end
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'(int'(org) + int'($urandom_range(0, 1000)) - 500);
   endfunction

   function automatic void check_field(string name, logic signed [p2h_pkg::CELL_W-1:0] want,
                                       logic signed [p2h_pkg::CELL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic put_reg(p2h_pkg::csr_index_type idx, logic [p2h_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         p2h_pkg::CSR_ORIGIN_X: lay.origin_x = val[p2h_pkg::PIX_W-1:0];
         p2h_pkg::CSR_ORIGIN_Y: lay.origin_y = val[p2h_pkg::PIX_W-1:0];
         p2h_pkg::CSR_INV_CELL_WIDTH: lay.inv_cell_width = val;
         p2h_pkg::CSR_INV_CELL_HEIGHT: lay.inv_cell_height = val;
         p2h_pkg::CSR_COEF_QX: lay.coef_qx = val[p2h_pkg::COEF_W-1:0];
         p2h_pkg::CSR_COEF_QY: lay.coef_qy = val[p2h_pkg::COEF_W-1:0];
         p2h_pkg::CSR_COEF_RX: lay.coef_rx = val[p2h_pkg::COEF_W-1:0];
         p2h_pkg::CSR_COEF_RY: lay.coef_ry = val[p2h_pkg::COEF_W-1:0];
         default: ;
      endcase
   endtask

   // upper bits of the 16-bit registers carry junk, which the block must drop
   task automatic load_layout(p2h_pkg::cfg_type c);
      put_reg(p2h_pkg::CSR_ORIGIN_X, {4'($urandom_range(0, 15)), c.origin_x});
      put_reg(p2h_pkg::CSR_ORIGIN_Y, {4'($urandom_range(0, 15)), c.origin_y});
      put_reg(p2h_pkg::CSR_INV_CELL_WIDTH, c.inv_cell_width);
      put_reg(p2h_pkg::CSR_INV_CELL_HEIGHT, c.inv_cell_height);
      put_reg(p2h_pkg::CSR_COEF_QX, {4'($urandom_range(0, 15)), c.coef_qx});
      put_reg(p2h_pkg::CSR_COEF_QY, {4'($urandom_range(0, 15)), c.coef_qy});
      put_reg(p2h_pkg::CSR_COEF_RX, {4'($urandom_range(0, 15)), c.coef_rx});
      put_reg(p2h_pkg::CSR_COEF_RY, {4'($urandom_range(0, 15)), c.coef_ry});
      csr_we <= 1'b0;
      layouts_loaded++;
   endtask

   // hold the input until the pipeline has emptied
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (p2h_pkg::NUM_STAGES + 2) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_pixel(logic signed [p2h_pkg::PIX_W-1:0] px,
                             logic signed [p2h_pkg::PIX_W-1:0] py,
                             bit typed, hex_cell_type want);
      pace();
      req_tvalid <= 1'b1;
      req_tdata <= {py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_cells.push_back(typed ? want : locate_cell(px, py));
      pixels_sent++;
   endtask

   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 3));
         sink_left = $urandom_range(32, 256);
      end
      sink_left--;
      sink_tick++;
      case (sink_mode)
         SINK_FREE: rsp_tready <= 1'b1;
         SINK_JITTER: rsp_tready <= ($urandom_range(0, 3) != 0);
         SINK_PERIODIC: rsp_tready <= (sink_tick % 5 < 3);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      hex_cell_type got;
      hex_cell_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.q = rsp_tdata[p2h_pkg::CELL_W-1:0];
         got.r = rsp_tdata[2*p2h_pkg::CELL_W-1:p2h_pkg::CELL_W];
         got.s = rsp_tdata[3*p2h_pkg::CELL_W-1:2*p2h_pkg::CELL_W];
         if (pending_cells.size() == 0) begin
            $display("%0t: cell transfer with none expected, got q=%0d r=%0d s=%0d",
                     $time, got.q, got.r, got.s);
            mismatches++;
         end else begin
            want = pending_cells.pop_front();
            cells_checked++;
            check_field("cell_q", want.q, got.q);
            check_field("cell_r", want.r, got.r);
            check_field("cell_s", want.s, got.s);
         end
      end
   end

   initial begin
      int cur;
      int n;
      lay_kind_type kind;
      lay = dir_lay[0];
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed rows, first ones on the reset layout
      cur = 0;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].lay != cur) begin
            settle();
            cur = dir_rows[i].lay;
            load_layout(dir_lay[cur]);
         end
         send_pixel(dir_rows[i].px, dir_rows[i].py, dir_rows[i].typed, dir_rows[i].want);
      end

      for (int ph = 0; pixels_sent < RUN_PIXELS; ph++) begin
         kind = lay_kind_type'(ph % 3);
         settle();
         load_layout(make_layout(kind));
         n = $urandom_range(60, 140);
         if (n > RUN_PIXELS - pixels_sent) n = RUN_PIXELS - pixels_sent;
         repeat (n) begin
            send_pixel(pick_coord(kind, lay.origin_x), pick_coord(kind, lay.origin_y),
                       1'b0, no_cell);
         end
      end

      settle();
      $display("tb: %0d pixels over %0d layouts (hex, half-step, extreme), %0d cells checked",
               pixels_sent, layouts_loaded, cells_checked);
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
